[hdl/dpb_pkg.sv]
`default_nettype none
package dpb_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT   = 3'd7;

    // z window in unsigned q8.16 (0.01 m to 10 m)
    localparam logic [23:0] Z_MIN_Q = 24'd656;
    localparam logic [23:0] Z_MAX_Q = 24'd655360;

    localparam int NORM_W     = 31;   // normalized ray component width
    localparam int PROD_W     = 55;   // depth times ray component
    localparam int RAD_W      = 64;   // sum of squares
    localparam int ROOT_W     = 32;   // ray length
    localparam int QUO_W      = 24;   // coordinate magnitude
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;

    typedef struct packed {
        logic [23:0] focal_x;
        logic [23:0] focal_y;
        logic [23:0] center_x;
        logic [23:0] center_y;
        logic [10:0] border_margin;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [31:0] variance_limit;
    } cfg_t;

    // per-point data that rides alongside the arithmetic
    typedef struct packed {
        logic       neg_x;
        logic       neg_y;
        logic [7:0] gray;
    } side_t;

endpackage
`default_nettype wire

[hdl/dpb_front.sv]
`default_nettype none
module dpb_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             adv,
    input  wire logic                             in_take,
    input  wire dpb_pkg::cfg_t                    cfg,
    input  wire logic [11:0]                      column,
    input  wire logic [11:0]                      row,
    input  wire logic [23:0]                      depth_value,
    input  wire logic [31:0]                      depth_variance,
    input  wire logic [7:0]                       gray_level,
    output logic                                  valid,
    output dpb_pkg::side_t                        side,
    output logic [dpb_pkg::RAD_W-1:0]             radicand,
    output logic [dpb_pkg::PROD_W-1:0]            prod_x,
    output logic [dpb_pkg::PROD_W-1:0]            prod_y,
    output logic [dpb_pkg::PROD_W-1:0]            prod_z
);

    // stage 1: window, variance, offsets from principal point
    logic [12:0] w_sat, h_sat;
    logic [12:0] u13, v13, m13;
    logic        pass;
    logic [23:0] us, vs;
    logic        nx_next, ny_next;
    logic [23:0] ax_next, ay_next, fx_next, fy_next;

    always_comb
    begin
        w_sat = (cfg.image_width > 13'(dpb_pkg::MAX_DIM)) ? 13'(dpb_pkg::MAX_DIM)
                                                          : cfg.image_width;
        h_sat = (cfg.image_height > 13'(dpb_pkg::MAX_DIM)) ? 13'(dpb_pkg::MAX_DIM)
                                                           : cfg.image_height;
        u13 = {1'b0, column};
        v13 = {1'b0, row};
        m13 = {2'b0, cfg.border_margin};
        pass = (u13 >= m13) && (u13 + m13 < w_sat) &&
               (v13 >= m13) && (v13 + m13 < h_sat) &&
               (depth_variance <= cfg.variance_limit);
        us = {4'b0, column, 8'h00};
        vs = {4'b0, row, 8'h00};
        nx_next = us < cfg.center_x;
        ny_next = vs < cfg.center_y;
        ax_next = nx_next ? cfg.center_x - us : us - cfg.center_x;
        ay_next = ny_next ? cfg.center_y - vs : vs - cfg.center_y;
        fx_next = (cfg.focal_x < 24'd256) ? 24'd256 : cfg.focal_x;
        fy_next = (cfg.focal_y < 24'd256) ? 24'd256 : cfg.focal_y;
    end

    logic        v1_reg;
    logic [23:0] ax_reg, ay_reg, fx_reg, fy_reg, d1_reg;
    dpb_pkg::side_t s1_reg;

    // stage 2: ray products
    logic        v2_reg;
    logic [47:0] mx_reg, my_reg, mz_reg;
    logic [23:0] d2_reg;
    dpb_pkg::side_t s2_reg;

    // stage 3: leading one of the largest component
    logic [47:0] mmax;
    logic [5:0]  pos_next;
    logic        v3_reg;
    logic [47:0] mx3_reg, my3_reg, mz3_reg;
    logic [5:0]  pos_reg;
    logic [23:0] d3_reg;
    dpb_pkg::side_t s3_reg;

    always_comb
    begin
        mmax = mz_reg;
        if (mx_reg > mmax)
        begin
            mmax = mx_reg;
        end
        if (my_reg > mmax)
        begin
            mmax = my_reg;
        end
        pos_next = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (mmax[i])
            begin
                pos_next = 6'(i);
            end
        end
    end

    // stage 4: shift so the largest lies in [2^30, 2^31)
    logic [47:0] nx4, ny4, nz4;
    logic [5:0]  rsh, lsh;
    logic        v4_reg;
    logic [dpb_pkg::NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic [23:0] d4_reg;
    dpb_pkg::side_t s4_reg;

    always_comb
    begin
        rsh = pos_reg - 6'd30;
        lsh = 6'd30 - pos_reg;
        if (pos_reg >= 6'd30)
        begin
            nx4 = mx3_reg >> rsh;
            ny4 = my3_reg >> rsh;
            nz4 = mz3_reg >> rsh;
        end
        else
        begin
            nx4 = mx3_reg << lsh;
            ny4 = my3_reg << lsh;
            nz4 = mz3_reg << lsh;
        end
    end

    // stage 5: squares and depth products
    logic        v5_reg;
    logic [61:0] qx_reg, qy_reg, qz_reg;
    logic [dpb_pkg::PROD_W-1:0] px5_reg, py5_reg, pz5_reg;
    dpb_pkg::side_t s5_reg;

    // stage 6: sum of squares
    logic        v6_reg;
    logic [dpb_pkg::RAD_W-1:0]  sum_reg;
    logic [dpb_pkg::PROD_W-1:0] px6_reg, py6_reg, pz6_reg;
    dpb_pkg::side_t s6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_take && pass;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            fx_reg <= fx_next;
            fy_reg <= fy_next;
            d1_reg <= depth_value;
            s1_reg <= '{neg_x: nx_next, neg_y: ny_next, gray: gray_level};

            mx_reg <= 48'(ax_reg) * 48'(fy_reg);
            my_reg <= 48'(ay_reg) * 48'(fx_reg);
            mz_reg <= 48'(fx_reg) * 48'(fy_reg);
            d2_reg <= d1_reg;
            s2_reg <= s1_reg;

            mx3_reg <= mx_reg;
            my3_reg <= my_reg;
            mz3_reg <= mz_reg;
            pos_reg <= pos_next;
            d3_reg  <= d2_reg;
            s3_reg  <= s2_reg;

            nx_reg <= nx4[dpb_pkg::NORM_W-1:0];
            ny_reg <= ny4[dpb_pkg::NORM_W-1:0];
            nz_reg <= nz4[dpb_pkg::NORM_W-1:0];
            d4_reg <= d3_reg;
            s4_reg <= s3_reg;

            qx_reg  <= 62'(nx_reg) * 62'(nx_reg);
            qy_reg  <= 62'(ny_reg) * 62'(ny_reg);
            qz_reg  <= 62'(nz_reg) * 62'(nz_reg);
            px5_reg <= dpb_pkg::PROD_W'(d4_reg) * dpb_pkg::PROD_W'(nx_reg);
            py5_reg <= dpb_pkg::PROD_W'(d4_reg) * dpb_pkg::PROD_W'(ny_reg);
            pz5_reg <= dpb_pkg::PROD_W'(d4_reg) * dpb_pkg::PROD_W'(nz_reg);
            s5_reg  <= s4_reg;

            sum_reg <= 64'(qx_reg) + 64'(qy_reg) + 64'(qz_reg);
            px6_reg <= px5_reg;
            py6_reg <= py5_reg;
            pz6_reg <= pz5_reg;
            s6_reg  <= s5_reg;
        end
    end

    assign valid    = v6_reg;
    assign side     = s6_reg;
    assign radicand = sum_reg;
    assign prod_x   = px6_reg;
    assign prod_y   = py6_reg;
    assign prod_z   = pz6_reg;

endmodule
`default_nettype wire

[hdl/dpb_sqrt.sv]
`default_nettype none
module dpb_sqrt (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             adv,
    input  wire logic                             in_valid,
    input  wire dpb_pkg::side_t                   in_side,
    input  wire logic [dpb_pkg::RAD_W-1:0]        radicand,
    input  wire logic [dpb_pkg::PROD_W-1:0]       in_px,
    input  wire logic [dpb_pkg::PROD_W-1:0]       in_py,
    input  wire logic [dpb_pkg::PROD_W-1:0]       in_pz,
    output logic                                  valid,
    output dpb_pkg::side_t                        side,
    output logic [dpb_pkg::ROOT_W-1:0]            root,
    output logic [dpb_pkg::PROD_W-1:0]            px,
    output logic [dpb_pkg::PROD_W-1:0]            py,
    output logic [dpb_pkg::PROD_W-1:0]            pz
);

    localparam int N = dpb_pkg::SQRT_STEPS;

    // one result bit per stage, two radicand bits brought down each time
    logic                           v_reg    [N];
    logic [33:0]                    rem_reg  [N];
    logic [dpb_pkg::ROOT_W-1:0]     root_reg [N];
    logic [dpb_pkg::RAD_W-1:0]      rad_reg  [N];
    dpb_pkg::side_t                 side_reg [N];
    logic [dpb_pkg::PROD_W-1:0]     px_reg   [N];
    logic [dpb_pkg::PROD_W-1:0]     py_reg   [N];
    logic [dpb_pkg::PROD_W-1:0]     pz_reg   [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [33:0]                rem_in;
        logic [dpb_pkg::ROOT_W-1:0] root_in;
        logic [dpb_pkg::RAD_W-1:0]  rad_in;
        logic                       v_in;
        dpb_pkg::side_t             side_in;
        logic [dpb_pkg::PROD_W-1:0] px_in, py_in, pz_in;
        logic [35:0]                trial, sub;
        logic [33:0]                rem_next;
        logic [dpb_pkg::ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign px_in   = in_px;
            assign py_in   = in_py;
            assign pz_in   = in_pz;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign v_in    = v_reg[k-1];
            assign side_in = side_reg[k-1];
            assign px_in   = px_reg[k-1];
            assign py_in   = py_reg[k-1];
            assign pz_in   = pz_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, rad_in[dpb_pkg::RAD_W-1 -: 2]};
            sub   = {2'b00, root_in, 2'b01};
            if (trial >= sub)
            begin
                rem_next  = 34'(trial - sub);
                root_next = {root_in[dpb_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[33:0];
                root_next = {root_in[dpb_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_in[dpb_pkg::RAD_W-3:0], 2'b00};
                side_reg[k] <= side_in;
                px_reg[k]   <= px_in;
                py_reg[k]   <= py_in;
                pz_reg[k]   <= pz_in;
            end
        end
    end

    assign valid = v_reg[N-1];
    assign side  = side_reg[N-1];
    assign root  = root_reg[N-1];
    assign px    = px_reg[N-1];
    assign py    = py_reg[N-1];
    assign pz    = pz_reg[N-1];

endmodule
`default_nettype wire

[hdl/dpb_div.sv]
`default_nettype none
module dpb_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             adv,
    input  wire logic                             in_valid,
    input  wire dpb_pkg::side_t                   in_side,
    input  wire logic [dpb_pkg::ROOT_W-1:0]       divisor,
    input  wire logic [dpb_pkg::PROD_W-1:0]       num_x,
    input  wire logic [dpb_pkg::PROD_W-1:0]       num_y,
    input  wire logic [dpb_pkg::PROD_W-1:0]       num_z,
    output logic                                  valid,
    output dpb_pkg::side_t                        side,
    output logic [dpb_pkg::QUO_W-1:0]             quo_x,
    output logic [dpb_pkg::QUO_W-1:0]             quo_y,
    output logic [dpb_pkg::QUO_W-1:0]             quo_z
);

    localparam int N  = dpb_pkg::DIV_STEPS;
    localparam int QW = dpb_pkg::QUO_W;
    localparam int RW = dpb_pkg::ROOT_W;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] low;
        logic [QW-1:0] quo;
    } lane_t;

    // the quotient stays below 2^24, so the top bits already sit under the divisor
    function automatic lane_t lane_load(input logic [dpb_pkg::PROD_W-1:0] num);
        lane_t l;
        l.rem = RW'(num[dpb_pkg::PROD_W-1:QW]);
        l.low = num[QW-1:0];
        l.quo = '0;
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t l, input logic [RW-1:0] d);
        lane_t       o;
        logic [RW:0] t;
        t     = {l.rem, l.low[QW-1]};
        o.low = {l.low[QW-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            o.rem = RW'(t - {1'b0, d});
            o.quo = {l.quo[QW-2:0], 1'b1};
        end
        else
        begin
            o.rem = t[RW-1:0];
            o.quo = {l.quo[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    logic            v_reg   [N];
    lane_t           lx_reg  [N];
    lane_t           ly_reg  [N];
    lane_t           lz_reg  [N];
    logic [RW-1:0]   d_reg   [N];
    dpb_pkg::side_t  s_reg   [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        lane_t          lx_in, ly_in, lz_in;
        logic [RW-1:0]  d_in;
        logic           v_in;
        dpb_pkg::side_t s_in;

        if (k == 0)
        begin : g_first
            assign lx_in = lane_load(num_x);
            assign ly_in = lane_load(num_y);
            assign lz_in = lane_load(num_z);
            assign d_in  = divisor;
            assign v_in  = in_valid;
            assign s_in  = in_side;
        end
        else
        begin : g_rest
            assign lx_in = lx_reg[k-1];
            assign ly_in = ly_reg[k-1];
            assign lz_in = lz_reg[k-1];
            assign d_in  = d_reg[k-1];
            assign v_in  = v_reg[k-1];
            assign s_in  = s_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lx_reg[k] <= lane_step(lx_in, d_in);
                ly_reg[k] <= lane_step(ly_in, d_in);
                lz_reg[k] <= lane_step(lz_in, d_in);
                d_reg[k]  <= d_in;
                s_reg[k]  <= s_in;
            end
        end
    end

    assign valid = v_reg[N-1];
    assign side  = s_reg[N-1];
    assign quo_x = lx_reg[N-1].quo;
    assign quo_y = ly_reg[N-1].quo;
    assign quo_z = lz_reg[N-1].quo;

endmodule
`default_nettype wire

[hdl/depth_pixel_backprojector.sv]
// Back-projects depth-image pixels into 3-D points, one pixel per clock. A pixel
// passes when it lies margin pixels inside the image and its variance is at or
// below the limit; its ray ((u-cx)/fx, (v-cy)/fy, 1) is normalized and scaled by
// the depth (a range along the ray), and the point is sent out with its gray
// byte only when z lies within 0.01 to 10 m, so rejected pixels give no beat.
// The path from input beat to output register runs through 6 front stages
// (window test, ray products, normalize search, shift, squares, sum), 32 stages
// of the bit-per-stage square root, 24 stages of the three-lane restoring
// divider and the output register. Throughput is one pixel per cycle; the
// pipeline only holds when the output register is full, stalled, and the last
// divider stage carries a point, so bubbles close up behind a stalled result.
// Configuration writes should be made while idle.
`default_nettype none
module depth_pixel_backprojector (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_write,
    input  wire logic [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel beats
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [11:0]                        column,
    input  wire logic [11:0]                        row,
    input  wire logic [23:0]                        depth_value,
    input  wire logic [31:0]                        depth_variance,
    input  wire logic [7:0]                         gray_level,
    // point beats
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [24:0]                      x_pos,
    output logic signed [24:0]                      y_pos,
    output logic [19:0]                             z_pos,
    output logic [7:0]                              point_gray
);

    // configuration registers
    dpb_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x        <= 24'd128000;
            cfg_reg.focal_y        <= 24'd128000;
            cfg_reg.center_x       <= 24'd81920;
            cfg_reg.center_y       <= 24'd61440;
            cfg_reg.border_margin  <= 11'd20;
            cfg_reg.image_width    <= 13'd640;
            cfg_reg.image_height   <= 13'd480;
            cfg_reg.variance_limit <= 32'd13107;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dpb_pkg::REG_FOCAL_X:   cfg_reg.focal_x        <= cfg_data[23:0];
                dpb_pkg::REG_FOCAL_Y:   cfg_reg.focal_y        <= cfg_data[23:0];
                dpb_pkg::REG_CENTER_X:  cfg_reg.center_x       <= cfg_data[23:0];
                dpb_pkg::REG_CENTER_Y:  cfg_reg.center_y       <= cfg_data[23:0];
                dpb_pkg::REG_BORDER:    cfg_reg.border_margin  <= cfg_data[10:0];
                dpb_pkg::REG_WIDTH:     cfg_reg.image_width    <= cfg_data[12:0];
                dpb_pkg::REG_HEIGHT:    cfg_reg.image_height   <= cfg_data[12:0];
                dpb_pkg::REG_VAR_LIMIT: cfg_reg.variance_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow control: the output register loads when empty or taken,
    // the rest of the pipe also moves when its last stage holds a bubble
    logic out_valid_reg;
    logic out_load;
    logic adv;
    logic div_valid;

    assign out_load = !out_valid_reg || !out_stall;
    assign adv      = out_load || !div_valid;
    assign in_stall = !adv;

    // front end: window/variance filter, ray, normalization, squares, depth products
    logic                           fe_valid;
    dpb_pkg::side_t                 fe_side;
    logic [dpb_pkg::RAD_W-1:0]      fe_rad;
    logic [dpb_pkg::PROD_W-1:0]     fe_px, fe_py, fe_pz;

    dpb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_take        (in_valid),
        .cfg            (cfg_reg),
        .column         (column),
        .row            (row),
        .depth_value    (depth_value),
        .depth_variance (depth_variance),
        .gray_level     (gray_level),
        .valid          (fe_valid),
        .side           (fe_side),
        .radicand       (fe_rad),
        .prod_x         (fe_px),
        .prod_y         (fe_py),
        .prod_z         (fe_pz)
    );

    // ray length
    logic                           sq_valid;
    dpb_pkg::side_t                 sq_side;
    logic [dpb_pkg::ROOT_W-1:0]     sq_root;
    logic [dpb_pkg::PROD_W-1:0]     sq_px, sq_py, sq_pz;

    dpb_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (fe_valid),
        .in_side  (fe_side),
        .radicand (fe_rad),
        .in_px    (fe_px),
        .in_py    (fe_py),
        .in_pz    (fe_pz),
        .valid    (sq_valid),
        .side     (sq_side),
        .root     (sq_root),
        .px       (sq_px),
        .py       (sq_py),
        .pz       (sq_pz)
    );

    // depth * component / length, three lanes side by side
    dpb_pkg::side_t                 dv_side;
    logic [dpb_pkg::QUO_W-1:0]      qx, qy, qz;

    dpb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (sq_valid),
        .in_side  (sq_side),
        .divisor  (sq_root),
        .num_x    (sq_px),
        .num_y    (sq_py),
        .num_z    (sq_pz),
        .valid    (div_valid),
        .side     (dv_side),
        .quo_x    (qx),
        .quo_y    (qy),
        .quo_z    (qz)
    );

    // z window and sign, then the output register
    logic        z_ok;
    logic [24:0] x_next, y_next;

    always_comb
    begin
        z_ok   = (qz >= dpb_pkg::Z_MIN_Q) && (qz <= dpb_pkg::Z_MAX_Q);
        x_next = dv_side.neg_x ? 25'(-{1'b0, qx}) : {1'b0, qx};
        y_next = dv_side.neg_y ? 25'(-{1'b0, qy}) : {1'b0, qy};
    end

    logic signed [24:0] x_reg, y_reg;
    logic [19:0]        z_reg;
    logic [7:0]         gray_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= div_valid && z_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= qz[19:0];
            gray_reg <= dv_side.gray;
        end
    end

    assign out_valid  = out_valid_reg;
    assign x_pos      = x_reg;
    assign y_pos      = y_reg;
    assign z_pos      = z_reg;
    assign point_gray = gray_reg;

endmodule
`default_nettype wire

[hdl/dpb_checker.sv]
`default_nettype none
module dpb_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [24:0] x_pos,
    input  wire logic signed [24:0] y_pos,
    input  wire logic [19:0]        z_pos,
    input  wire logic [7:0]         point_gray
);

    // a stalled point stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("point beat dropped while stalled");

    // a stalled point keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(x_pos) && $stable(y_pos) &&
                                   $stable(z_pos) && $stable(point_gray))
        else $error("point payload changed while stalled");

    // only points inside the depth window leave the block
    a_z_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (z_pos >= 20'd656) && (z_pos <= 20'd655360))
        else $error("point outside z window");

    // coordinate magnitudes stay below 2^24
    a_xy_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (x_pos != 25'sh1000000) && (y_pos != 25'sh1000000))
        else $error("coordinate magnitude overflow");

endmodule

bind depth_pixel_backprojector dpb_checker u_dpb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .z_pos      (z_pos),
    .point_gray (point_gray)
);
`default_nettype wire

[verif/tb_depth_pixel_backprojector.sv]
`timescale 1ns / 100ps
module tb_depth_pixel_backprojector;

    // one pixel beat on the input side
    typedef struct {
        logic [11:0] column;
        logic [11:0] row;
        logic [23:0] depth_value;
        logic [31:0] depth_variance;
        logic [7:0]  gray_level;
    } pixel_t;

    // one point beat on the output side
    typedef struct {
        logic [24:0] x_pos;
        logic [24:0] y_pos;
        logic [19:0] z_pos;
        logic [7:0]  point_gray;
    } point_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index = dpb_pkg::REG_FOCAL_X;
    logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [11:0]                    column = '0;
    logic [11:0]                    row = '0;
    logic [23:0]                    depth_value = '0;
    logic [31:0]                    depth_variance = '0;
    logic [7:0]                     gray_level = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [24:0]             x_pos;
    logic signed [24:0]             y_pos;
    logic [19:0]                    z_pos;
    logic [7:0]                     point_gray;

    depth_pixel_backprojector dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .column         (column),
        .row            (row),
        .depth_value    (depth_value),
        .depth_variance (depth_variance),
        .gray_level     (gray_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .x_pos          (x_pos),
        .y_pos          (y_pos),
        .z_pos          (z_pos),
        .point_gray     (point_gray)
    );

    always #5 clk = ~clk;

    // pixels waiting to be sent, points waiting to come back
    pixel_t pending_pixels[$];
    point_t expected_points[$];

    // local copy of the register file, kept in step with every write
    dpb_pkg::cfg_t cam;

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     beat_taken = 1'b0;
    bit     failed = 1'b0;
    bit     hold_kick = 1'b0;
    bit     hold_seen = 1'b0;
    int     hold_left = 0;

    // back-projection of one pixel; returns 1 when a point comes out
    function automatic bit backproject(pixel_t p, output point_t pt);
        longint unsigned fx, fy, us, vs, ax, ay, mx, my, mz, m;
        longint unsigned rad, root, bitv, xm, ym, zq, w, h, margin;
        bit nx, ny;
        pt = '{default: '0};
        fx = (cam.focal_x < 256) ? 256 : cam.focal_x;
        fy = (cam.focal_y < 256) ? 256 : cam.focal_y;
        w = (cam.image_width > dpb_pkg::MAX_DIM) ? dpb_pkg::MAX_DIM : cam.image_width;
        h = (cam.image_height > dpb_pkg::MAX_DIM) ? dpb_pkg::MAX_DIM : cam.image_height;
        margin = cam.border_margin;
        // border window, empty when the margins overlap
        if (!(p.column >= margin && p.column + margin < w)) return 1'b0;
        if (!(p.row >= margin && p.row + margin < h)) return 1'b0;
        if (p.depth_variance > cam.variance_limit) return 1'b0;
        us = longint'(p.column) << 8;
        vs = longint'(p.row) << 8;
        nx = us < cam.center_x;
        ny = vs < cam.center_y;
        ax = nx ? cam.center_x - us : us - cam.center_x;
        ay = ny ? cam.center_y - vs : vs - cam.center_y;
        mx = ax * fy;
        my = ay * fx;
        mz = fx * fy;
        m = mz;
        if (mx > m) m = mx;
        if (my > m) m = my;
        // bring the largest component into [2^30, 2^31)
        while (m >= 64'd1 << 31) begin
            m = m >> 1; mx = mx >> 1; my = my >> 1; mz = mz >> 1;
        end
        while (m < 64'd1 << 30) begin
            m = m << 1; mx = mx << 1; my = my << 1; mz = mz << 1;
        end
        // digit-by-digit integer square root of the ray length squared
        rad = mx * mx + my * my + mz * mz;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rad) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rad >= root + bitv) begin
                rad = rad - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (root == 0) root = 1;
        xm = p.depth_value * mx / root;
        ym = p.depth_value * my / root;
        zq = p.depth_value * mz / root;
        if (zq < dpb_pkg::Z_MIN_Q || zq > dpb_pkg::Z_MAX_Q) return 1'b0;
        pt.x_pos = 25'(nx ? 64'd0 - xm : xm);
        pt.y_pos = 25'(ny ? 64'd0 - ym : ym);
        pt.z_pos = 20'(zq);
        pt.point_gray = p.gray_level;
        return 1'b1;
    endfunction

    function automatic pixel_t make_pixel(int u, int v, int d, logic [31:0] var_q, int g);
        pixel_t p;
        p.column = 12'(u);
        p.row = 12'(v);
        p.depth_value = 24'(d);
        p.depth_variance = var_q;
        p.gray_level = 8'(g);
        return p;
    endfunction

    // append to the send queue
    function automatic void add_pixel(pixel_t p);
        pending_pixels.insert(pending_pixels.size(), p);
    endfunction

    // mostly in-window pixels within the variance limit with random content, the rest raw noise
    function automatic pixel_t random_pixel();
        pixel_t p;
        int w, h, mg;
        w = (cam.image_width > dpb_pkg::MAX_DIM) ? dpb_pkg::MAX_DIM : cam.image_width;
        h = (cam.image_height > dpb_pkg::MAX_DIM) ? dpb_pkg::MAX_DIM : cam.image_height;
        mg = cam.border_margin;
        p = make_pixel($urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(99) < 82) begin
            if (w - mg - 1 >= mg) p.column = 12'($urandom_range(w - mg - 1, mg));
            if (h - mg - 1 >= mg) p.row = 12'($urandom_range(h - mg - 1, mg));
            if ($urandom_range(3) != 0) p.depth_value = 24'($urandom_range(700000, 656));
            p.depth_variance = $urandom_range(cam.variance_limit, 0);
        end
        return p;
    endfunction

    task automatic write_reg(logic [dpb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            dpb_pkg::REG_FOCAL_X:   cam.focal_x = val[23:0];
            dpb_pkg::REG_FOCAL_Y:   cam.focal_y = val[23:0];
            dpb_pkg::REG_CENTER_X:  cam.center_x = val[23:0];
            dpb_pkg::REG_CENTER_Y:  cam.center_y = val[23:0];
            dpb_pkg::REG_BORDER:    cam.border_margin = val[10:0];
            dpb_pkg::REG_WIDTH:     cam.image_width = val[12:0];
            dpb_pkg::REG_HEIGHT:    cam.image_height = val[12:0];
            dpb_pkg::REG_VAR_LIMIT: cam.variance_limit = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_camera(logic [23:0] fx, logic [23:0] fy, logic [23:0] cx,
                               logic [23:0] cy, logic [10:0] mg, logic [12:0] w,
                               logic [12:0] h, logic [31:0] vl);
        write_reg(dpb_pkg::REG_FOCAL_X, 32'(fx));
        write_reg(dpb_pkg::REG_FOCAL_Y, 32'(fy));
        write_reg(dpb_pkg::REG_CENTER_X, 32'(cx));
        write_reg(dpb_pkg::REG_CENTER_Y, 32'(cy));
        write_reg(dpb_pkg::REG_BORDER, 32'(mg));
        write_reg(dpb_pkg::REG_WIDTH, 32'(w));
        write_reg(dpb_pkg::REG_HEIGHT, 32'(h));
        write_reg(dpb_pkg::REG_VAR_LIMIT, vl);
    endtask

    // wait for every queued pixel to go in and every point to come out,
    // then let rejected pixels still in the pipe flush through
    task automatic wait_idle();
        do begin
            @(posedge clk);
            #1;
        end while (pending_pixels.size() != 0 || in_valid || expected_points.size() != 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        repeat (count) add_pixel(random_pixel());
    endtask

    // pixel driver: new beat at the falling edge once the last one was taken
    always @(negedge clk) begin
        if (rst_n && (!in_valid || beat_taken)) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                pixel_t p;
                p = pending_pixels.pop_front();
                column <= p.column;
                row <= p.row;
                depth_value <= p.depth_value;
                depth_variance <= p.depth_variance;
                gray_level <= p.gray_level;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: a kick from the stimulus starts a long hold-off
    always @(negedge clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= 400;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // accepted pixel beats feed the predictor
    always @(posedge clk) begin
        point_t pt;
        beat_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            if (backproject(make_pixel(column, row, depth_value, depth_variance, gray_level), pt))
                expected_points.insert(expected_points.size(), pt);
        end
    end

    // accepted point beats are checked against the oldest prediction
    always @(posedge clk) begin
        point_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point beat x=%0d y=%0d z=%0d", x_pos, y_pos, z_pos);
                failed = 1'b1;
            end else begin
                want = expected_points.pop_front();
                if (x_pos !== want.x_pos) begin
                    $error("x_pos expected %0d got %0d", $signed(want.x_pos), x_pos);
                    failed = 1'b1;
                end
                if (y_pos !== want.y_pos) begin
                    $error("y_pos expected %0d got %0d", $signed(want.y_pos), y_pos);
                    failed = 1'b1;
                end
                if (z_pos !== want.z_pos) begin
                    $error("z_pos expected %0d got %0d", want.z_pos, z_pos);
                    failed = 1'b1;
                end
                if (point_gray !== want.point_gray) begin
                    $error("point_gray expected %0d got %0d", want.point_gray, point_gray);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        cam = '{focal_x: 24'd128000, focal_y: 24'd128000, center_x: 24'd81920,
                center_y: 24'd61440, border_margin: 11'd20, image_width: 13'd640,
                image_height: 13'd480, variance_limit: 32'd13107};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pass at the reset settings
        send_idle_pct = 29;
        recv_idle_pct = 65;
        // principal point at 1 m and at the z window limits
        add_pixel(make_pixel(320, 240, 65536, 0, 255));
        add_pixel(make_pixel(320, 240, 656, 0, 1));
        add_pixel(make_pixel(320, 240, 655, 0, 2));
        add_pixel(make_pixel(320, 240, 655360, 0, 3));
        add_pixel(make_pixel(320, 240, 655361, 0, 4));
        add_pixel(make_pixel(320, 240, 0, 0, 5));
        // window corners and the first pixel outside each edge
        add_pixel(make_pixel(20, 20, 200000, 100, 0));
        add_pixel(make_pixel(619, 459, 200000, 100, 128));
        add_pixel(make_pixel(19, 100, 200000, 100, 6));
        add_pixel(make_pixel(620, 100, 200000, 100, 7));
        add_pixel(make_pixel(100, 19, 200000, 100, 8));
        add_pixel(make_pixel(100, 460, 200000, 100, 9));
        add_pixel(make_pixel(4095, 4095, 16777215, 0, 10));
        add_pixel(make_pixel(0, 0, 100000, 0, 11));
        // variance right at and just over the limit
        add_pixel(make_pixel(400, 300, 300000, 13107, 12));
        add_pixel(make_pixel(400, 300, 300000, 13108, 13));
        add_pixel(make_pixel(400, 300, 300000, 32'hFFFFFFFF, 14));
        // deepest range that can still land inside the z window off axis
        add_pixel(make_pixel(619, 20, 16777215, 0, 15));
        add_pixel(make_pixel(21, 458, 700000, 0, 16));
        queue_random(260);
        wait_idle();

        // extreme settings: focal registers below one pixel, far principal point,
        // no margin, width at max and height saturating above max
        send_idle_pct = 65;
        recv_idle_pct = 29;
        load_camera(24'd0, 24'd100, 24'd0, 24'hFFFFFF, 11'd0, 13'd4096, 13'd8191,
                    32'hFFFFFFFF);
        add_pixel(make_pixel(0, 0, 16777215, 32'hFFFFFFFF, 255));
        add_pixel(make_pixel(4095, 4095, 16777215, 0, 0));
        queue_random(260);
        wait_idle();

        // longest focal lengths and the widest margin that still leaves a window
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_camera(24'hFFFFFF, 24'hFFFFFF, 24'($urandom), 24'($urandom), 11'd2047,
                    13'd4096, 13'd4096, 32'($urandom));
        add_pixel(make_pixel(2047, 2048, 655360, 0, 77));
        add_pixel(make_pixel(2046, 2048, 655360, 0, 78));
        queue_random(60);
        wait_idle();

        // typical camera; hold the output while the sender keeps pushing
        load_camera(24'($urandom_range(400000, 256)), 24'($urandom_range(400000, 256)),
                    24'($urandom_range(400000, 0)), 24'($urandom_range(400000, 0)),
                    11'($urandom_range(60, 0)), 13'($urandom_range(1500, 64)),
                    13'($urandom_range(1500, 64)), $urandom);
        queue_random(240);
        @(negedge clk);
        hold_kick = ~hold_kick;
        wait_idle();

        // empty window and zero variance limit
        load_camera(24'd128000, 24'd128000, 24'd81920, 24'd61440, 11'd5, 13'd0,
                    13'd480, 32'd0);
        queue_random(30);
        wait_idle();
        write_reg(dpb_pkg::REG_WIDTH, 32'd640);
        add_pixel(make_pixel(320, 240, 65536, 0, 90));
        add_pixel(make_pixel(320, 240, 65536, 1, 91));
        queue_random(60);
        wait_idle();

        if (!failed)
            $display("depth_pixel_backprojector regression: pass");
        else
            $display("depth_pixel_backprojector regression: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("depth_pixel_backprojector regression: fail");
        $finish;
    end

endmodule

[filelist.f]
hdl/dpb_pkg.sv
hdl/dpb_front.sv
hdl/dpb_sqrt.sv
hdl/dpb_div.sv
hdl/depth_pixel_backprojector.sv
hdl/dpb_checker.sv
verif/tb_depth_pixel_backprojector.sv
